// ===== sv/pll_pkg.sv =====
// Package with shared constants, codes and handshake types of the pooled linked list engine.
`timescale 1ns / 1ps

package pll_pkg;

  // Pool and list sizing.
  localparam int POOL_SIZE = 16;
  localparam int NUM_LISTS = 8;
  localparam int IDX_W     = $clog2(POOL_SIZE);
  localparam int LINK_W    = $clog2(POOL_SIZE + 1);
  localparam int STEP_W    = $clog2(POOL_SIZE + 1);
  localparam int LIST_W    = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
  localparam logic [LINK_W-1:0] NIL = LINK_W'(POOL_SIZE);

  // Field widths of the request and result items.
  localparam int FUNC_W      = 3;
  localparam int VALUE_W     = 8;
  localparam int LID_W       = 3;
  localparam int STATUS_W    = 3;
  localparam int NODE_W      = 4;
  localparam int CNT_W       = 5;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 16;

  // Command codes.
  localparam logic [FUNC_W-1:0] FUNC_CREATE = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_APPEND = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_SEARCH = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_INSERT = 3'd4;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOSLOT   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_UNUSED   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_WALK,
    S_GRAB,
    S_LINK,
    S_UNLINK,
    S_FREE,
    S_DONE
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                load_in;
    logic                walk_start;
    logic                walk_step;
    logic                tail_mode;
    logic                key_after;
    logic                grab;
    logic                grab_keep_next;
    logic                create_head;
    logic                link_new;
    logic                unlink;
    logic                free_node;
    logic                load_out;
    logic [STATUS_W-1:0] status;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              used;
    logic              pool_empty;
    logic              slot_free;
    logic              walk_done;
    logic              walk_found;
  } stat_t;

endpackage

// ===== sv/pll_dp.sv =====
// Datapath of the pooled linked list engine: node stores, list heads, free list and walker.
`timescale 1ns / 1ps

module pll_dp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [pll_pkg::IN_TDATA_W-1:0]     req_data_i,
  input  pll_pkg::cmd_t                      cmd_i,
  output pll_pkg::stat_t                     stat_o,
  output logic [pll_pkg::OUT_TDATA_W-1:0]    res_data_o
);

  // Latched request fields.
  logic [pll_pkg::FUNC_W-1:0]  func_q;
  logic [pll_pkg::VALUE_W-1:0] val_q;
  logic [pll_pkg::LID_W-1:0]   lid_q;
  logic [pll_pkg::VALUE_W-1:0] aft_q;

  // Walker state.
  logic [pll_pkg::LINK_W-1:0] cur_q, prev_q, nxt_q;
  logic [pll_pkg::STEP_W-1:0] steps_q;
  logic [pll_pkg::IDX_W-1:0]  idx_q;
  logic [pll_pkg::LID_W-1:0]  newid_q;

  // Pool state.
  logic [pll_pkg::LINK_W-1:0]  free_head_q;
  logic [pll_pkg::CNT_W-1:0]   count_q;
  logic [pll_pkg::LINK_W-1:0]  head_q [pll_pkg::NUM_LISTS];
  logic [pll_pkg::LINK_W-1:0]  link_q [pll_pkg::POOL_SIZE];
  logic [pll_pkg::POOL_SIZE-1:0] link_vld_q;
  logic [pll_pkg::VALUE_W-1:0] val_mem_q [pll_pkg::POOL_SIZE];

  logic [pll_pkg::OUT_TDATA_W-1:0] res_q;

  logic [pll_pkg::IDX_W-1:0]   rd_addr;
  logic [pll_pkg::LINK_W-1:0]  link_rd;
  logic [pll_pkg::VALUE_W-1:0] val_rd;
  logic [pll_pkg::VALUE_W-1:0] key;
  logic                        lid_ok;
  logic [pll_pkg::LIST_W-1:0]  lid_idx;
  logic [pll_pkg::LINK_W-1:0]  head_sel;
  logic                        used;
  logic                        pool_empty;
  logic                        slot_free;
  logic [pll_pkg::LIST_W-1:0]  slot;
  logic                        walk_done;
  logic                        walk_found;
  logic                        lw_en;
  logic [pll_pkg::IDX_W-1:0]   lw_addr;
  logic [pll_pkg::LINK_W-1:0]  lw_data;
  logic                        res_ok;

  // One read port shared by the walker and the allocator.
  assign rd_addr = cmd_i.grab ? free_head_q[pll_pkg::IDX_W-1:0] : cur_q[pll_pkg::IDX_W-1:0];
  assign link_rd = link_vld_q[rd_addr] ? link_q[rd_addr]
                                       : pll_pkg::LINK_W'(rd_addr) + pll_pkg::LINK_W'(1);
  assign val_rd  = val_mem_q[rd_addr];
  assign key     = cmd_i.key_after ? aft_q : val_q;

  assign lid_ok     = 32'(lid_q) < pll_pkg::NUM_LISTS;
  assign lid_idx    = lid_q[pll_pkg::LIST_W-1:0];
  assign head_sel   = head_q[lid_idx];
  assign used       = lid_ok && (head_sel < pll_pkg::NIL);
  assign pool_empty = (count_q >= pll_pkg::CNT_W'(pll_pkg::POOL_SIZE)) ||
                      (free_head_q >= pll_pkg::NIL);

  // Lowest unused list slot.
  always_comb begin
    slot_free = 1'b0;
    slot      = '0;
    for (int i = pll_pkg::NUM_LISTS - 1; i >= 0; i--) begin
      if (head_q[i] >= pll_pkg::NIL) begin
        slot_free = 1'b1;
        slot      = pll_pkg::LIST_W'(i);
      end
    end
  end

  // Walk termination: a tail walk stops at a null link, a search walk at a match or list end.
  always_comb begin
    if (cmd_i.tail_mode) begin
      walk_done  = (steps_q >= pll_pkg::STEP_W'(pll_pkg::POOL_SIZE)) ||
                   (link_rd >= pll_pkg::NIL);
      walk_found = 1'b1;
    end else if ((steps_q >= pll_pkg::STEP_W'(pll_pkg::POOL_SIZE)) ||
                 (cur_q >= pll_pkg::NIL)) begin
      walk_done  = 1'b1;
      walk_found = 1'b0;
    end else begin
      walk_done  = (val_rd == key);
      walk_found = walk_done;
    end
  end

  assign stat_o = '{func:       func_q,
                    used:       used,
                    pool_empty: pool_empty,
                    slot_free:  slot_free,
                    walk_done:  walk_done,
                    walk_found: walk_found};

  // Single write port of the link store.
  always_comb begin
    lw_en   = 1'b0;
    lw_addr = cur_q[pll_pkg::IDX_W-1:0];
    lw_data = pll_pkg::NIL;
    if (cmd_i.grab) begin
      lw_en   = 1'b1;
      lw_addr = free_head_q[pll_pkg::IDX_W-1:0];
      lw_data = cmd_i.grab_keep_next ? nxt_q : pll_pkg::NIL;
    end else if (cmd_i.link_new) begin
      lw_en   = 1'b1;
      lw_data = pll_pkg::LINK_W'(idx_q);
    end else if (cmd_i.unlink && (prev_q < pll_pkg::NIL)) begin
      lw_en   = 1'b1;
      lw_addr = prev_q[pll_pkg::IDX_W-1:0];
      lw_data = nxt_q;
    end else if (cmd_i.free_node) begin
      lw_en   = 1'b1;
      lw_data = free_head_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (lw_en) begin
      link_q[lw_addr] <= lw_data;
    end
    if (cmd_i.grab) begin
      val_mem_q[rd_addr] <= val_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_vld_q  <= '0;
      free_head_q <= '0;
      count_q     <= '0;
      for (int i = 0; i < pll_pkg::NUM_LISTS; i++) begin
        head_q[i] <= pll_pkg::NIL;
      end
    end else begin
      if (lw_en) begin
        link_vld_q[lw_addr] <= 1'b1;
      end
      if (cmd_i.grab) begin
        free_head_q <= (link_rd > pll_pkg::NIL) ? pll_pkg::NIL : link_rd;
        count_q     <= count_q + pll_pkg::CNT_W'(1);
        if (cmd_i.create_head) begin
          head_q[slot] <= free_head_q;
        end
      end
      if (cmd_i.unlink && (prev_q >= pll_pkg::NIL)) begin
        head_q[lid_idx] <= nxt_q;
      end
      if (cmd_i.free_node) begin
        free_head_q <= cur_q;
        if (count_q != '0) begin
          count_q <= count_q - pll_pkg::CNT_W'(1);
        end
      end
    end
  end

  assign res_ok = (cmd_i.status == pll_pkg::ST_OK);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      func_q  <= req_data_i[2:0];
      val_q   <= req_data_i[10:3];
      lid_q   <= req_data_i[13:11];
      aft_q   <= req_data_i[21:14];
      idx_q   <= '0;
      newid_q <= '0;
    end
    if (cmd_i.walk_start) begin
      cur_q   <= head_sel;
      prev_q  <= pll_pkg::NIL;
      steps_q <= cmd_i.tail_mode ? pll_pkg::STEP_W'(1) : '0;
    end
    if (cmd_i.walk_step) begin
      nxt_q <= link_rd;
      if (!walk_done) begin
        prev_q  <= cur_q;
        cur_q   <= link_rd;
        steps_q <= steps_q + pll_pkg::STEP_W'(1);
      end else if (walk_found && !cmd_i.tail_mode) begin
        idx_q <= cur_q[pll_pkg::IDX_W-1:0];
      end
    end
    if (cmd_i.grab) begin
      idx_q <= free_head_q[pll_pkg::IDX_W-1:0];
      if (cmd_i.create_head) begin
        newid_q <= pll_pkg::LID_W'(slot);
      end
    end
    if (cmd_i.load_out) begin
      res_q <= {1'b0,
                count_q,
                res_ok ? newid_q : pll_pkg::LID_W'(0),
                res_ok ? pll_pkg::NODE_W'(idx_q) : pll_pkg::NODE_W'(0),
                cmd_i.status};
    end
  end

  assign res_data_o = res_q;

endmodule

// ===== sv/pll_ctrl.sv =====
// Controller state machine of the pooled linked list engine.
`timescale 1ns / 1ps

module pll_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  output logic           req_ready_o,
  output logic           res_valid_o,
  input  logic           res_ready_i,
  input  pll_pkg::stat_t stat_i,
  output pll_pkg::cmd_t  cmd_o
);

  pll_pkg::state_e state_q, state_d;
  logic [pll_pkg::STATUS_W-1:0] status_q, status_d;
  logic res_valid_q;
  logic out_free;

  assign out_free = !res_valid_q || res_ready_i;

  // Next state and result status.
  always_comb begin
    state_d  = state_q;
    status_d = status_q;
    unique case (state_q)
      pll_pkg::S_IDLE: begin
        if (req_valid_i) begin
          state_d  = pll_pkg::S_CHECK;
          status_d = pll_pkg::ST_OK;
        end
      end
      pll_pkg::S_CHECK: begin
        unique case (stat_i.func) inside
          pll_pkg::FUNC_CREATE: begin
            if (stat_i.pool_empty) begin
              state_d  = pll_pkg::S_DONE;
              status_d = pll_pkg::ST_FULL;
            end else if (!stat_i.slot_free) begin
              state_d  = pll_pkg::S_DONE;
              status_d = pll_pkg::ST_NOSLOT;
            end else begin
              state_d = pll_pkg::S_GRAB;
            end
          end
          pll_pkg::FUNC_APPEND, pll_pkg::FUNC_INSERT: begin
            if (!stat_i.used) begin
              state_d  = pll_pkg::S_DONE;
              status_d = pll_pkg::ST_UNUSED;
            end else if (stat_i.pool_empty) begin
              state_d  = pll_pkg::S_DONE;
              status_d = pll_pkg::ST_FULL;
            end else begin
              state_d = pll_pkg::S_WALK;
            end
          end
          pll_pkg::FUNC_SEARCH, pll_pkg::FUNC_REMOVE: begin
            if (!stat_i.used) begin
              state_d  = pll_pkg::S_DONE;
              status_d = pll_pkg::ST_UNUSED;
            end else begin
              state_d = pll_pkg::S_WALK;
            end
          end
          default: begin
            state_d = pll_pkg::S_DONE;
          end
        endcase
      end
      pll_pkg::S_WALK: begin
        if (stat_i.walk_done) begin
          if (!stat_i.walk_found) begin
            state_d  = pll_pkg::S_DONE;
            status_d = pll_pkg::ST_NOTFOUND;
          end else begin
            unique case (stat_i.func) inside
              pll_pkg::FUNC_APPEND, pll_pkg::FUNC_INSERT: state_d = pll_pkg::S_GRAB;
              pll_pkg::FUNC_REMOVE:                       state_d = pll_pkg::S_UNLINK;
              default:                                    state_d = pll_pkg::S_DONE;
            endcase
          end
        end
      end
      pll_pkg::S_GRAB: begin
        state_d = (stat_i.func == pll_pkg::FUNC_CREATE) ? pll_pkg::S_DONE : pll_pkg::S_LINK;
      end
      pll_pkg::S_LINK:   state_d = pll_pkg::S_DONE;
      pll_pkg::S_UNLINK: state_d = pll_pkg::S_FREE;
      pll_pkg::S_FREE:   state_d = pll_pkg::S_DONE;
      pll_pkg::S_DONE: begin
        if (out_free) begin
          state_d = pll_pkg::S_IDLE;
        end
      end
      default: state_d = pll_pkg::S_IDLE;
    endcase
  end

  // Datapath commands.
  always_comb begin
    cmd_o                = '0;
    cmd_o.status         = status_q;
    cmd_o.tail_mode      = (stat_i.func == pll_pkg::FUNC_APPEND);
    cmd_o.key_after      = (stat_i.func == pll_pkg::FUNC_INSERT);
    cmd_o.create_head    = (stat_i.func == pll_pkg::FUNC_CREATE);
    cmd_o.grab_keep_next = (stat_i.func == pll_pkg::FUNC_INSERT);
    unique case (state_q)
      pll_pkg::S_IDLE:   cmd_o.load_in    = req_valid_i;
      pll_pkg::S_CHECK:  cmd_o.walk_start = (state_d == pll_pkg::S_WALK);
      pll_pkg::S_WALK:   cmd_o.walk_step  = 1'b1;
      pll_pkg::S_GRAB:   cmd_o.grab       = 1'b1;
      pll_pkg::S_LINK:   cmd_o.link_new   = 1'b1;
      pll_pkg::S_UNLINK: cmd_o.unlink     = 1'b1;
      pll_pkg::S_FREE:   cmd_o.free_node  = 1'b1;
      pll_pkg::S_DONE:   cmd_o.load_out   = out_free;
      default:           cmd_o.load_in    = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pll_pkg::S_IDLE;
      status_q    <= pll_pkg::ST_OK;
      res_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      status_q <= status_d;
      if (cmd_o.load_out) begin
        res_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  assign req_ready_o = (state_q == pll_pkg::S_IDLE);
  assign res_valid_o = res_valid_q;

endmodule

// ===== sv/pooled_linked_list_engine.sv =====
// Top level of the pooled linked list engine: controller plus datapath behind stream ports.
// Flow: each request passes a check, then for append, insert, search and remove a walk
//   over the addressed list that visits up to 16 nodes, then any link updates.
// Requests are taken one at a time; the walk over the link store runs one node per
//   cycle through its single read port.
// Reset: rst_ni clears the pool to a full free list 0..15, all lists unused,
//   and drops any pending result; the controller leaves reset idle and ready.
`timescale 1ns / 1ps

module pooled_linked_list_engine (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Request channel.
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // Fields from bit 0 up: func[2:0], value[10:3], list_id[13:11], after_value[21:14],
  // zero pad[23:22].
  input  logic [pll_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // Result channel.
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // Fields from bit 0 up: status[2:0], node_index[6:3], new_list_id[9:7],
  // nodes_in_use[14:10], zero pad[15].
  output logic [pll_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

  // The controller sequences each request through a check, an optional walk of the
  // addressed list, and the link updates; the datapath holds the stores and request fields.
  // Commands travel as one struct to the datapath, and its flags come back as another.
  pll_pkg::cmd_t  cmd;
  pll_pkg::stat_t stat;

  pll_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // The result sits in an output register, so a finished result may wait for the
  // consumer while the controller returns to idle and accepts the next request.
  pll_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_data_i (s_axis_tdata),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .res_data_o (m_axis_tdata)
  );

endmodule

// ===== sv/pll_checker.sv =====
// Port-level checker of the pooled linked list engine and its bind.
`timescale 1ns / 1ps

module pll_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic [pll_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [pll_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  logic [pll_pkg::STATUS_W-1:0] res_status;
  logic [pll_pkg::CNT_W-1:0]    res_count;

  assign res_status = m_axis_tdata[2:0];
  assign res_count  = m_axis_tdata[14:10];

  // A stalled result stays valid.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // A stalled result keeps its data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result data changed while stalled");

  // The node count never exceeds the pool.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> res_count <= pll_pkg::CNT_W'(pll_pkg::POOL_SIZE))
    else $error("node count above pool size");

  // A failed command reports no node and no list slot.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (res_status != pll_pkg::ST_OK) |->
      (m_axis_tdata[9:3] == '0))
    else $error("index fields set on an error result");

  // Only defined status codes appear.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> res_status <= pll_pkg::ST_NOTFOUND)
    else $error("undefined status code");

endmodule

bind pooled_linked_list_engine pll_checker u_pll_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== sim/tb_top.sv =====
// Self-checking testbench of the pooled linked list engine with a built-in pool and list predictor.
`timescale 1ns / 1ps

module tb_top;
  import pll_pkg::*;

  // Command codes that the block treats as no-ops.
  localparam logic [FUNC_W-1:0] FUNC_RSVD5 = 3'd5;
  localparam logic [FUNC_W-1:0] FUNC_RSVD7 = 3'd7;

  localparam int unsigned STALL_CYCLES = 400;
  localparam int unsigned DRAIN_CYCLES = 30;
  localparam int unsigned MAX_REPORTS  = 100;

  // Request fields, first field in the lowest bits.
  typedef struct packed {
    logic [VALUE_W-1:0] after_value;
    logic [LID_W-1:0]   list_id;
    logic [VALUE_W-1:0] value;
    logic [FUNC_W-1:0]  func;
  } command_t;

  // Result fields, first field in the lowest bits.
  typedef struct packed {
    logic [CNT_W-1:0]    nodes_in_use;
    logic [LID_W-1:0]    new_list_id;
    logic [NODE_W-1:0]   node_index;
    logic [STATUS_W-1:0] status;
  } outcome_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  // Predictor copy of the node pool and the list heads.
  logic [VALUE_W-1:0] node_value [POOL_SIZE];
  logic [LINK_W-1:0]  node_link  [POOL_SIZE];
  logic [LINK_W-1:0]  list_head  [NUM_LISTS];
  logic [LINK_W-1:0]  free_ptr;
  int unsigned        node_total;

  command_t    command_queue [$];
  outcome_t    expected_results [$];
  int unsigned mismatch_count = 0;
  int unsigned result_count = 0;
  int unsigned tx_idle_pct = 19;
  int unsigned rx_idle_pct = 52;
  logic        hold_go = 1'b0;
  int unsigned hold_left = 0;

  pooled_linked_list_engine u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  task automatic flag_mismatch(string what, logic [15:0] got, logic [15:0] want);
    if (mismatch_count < MAX_REPORTS) begin
      $display("MISMATCH result %0d %s: got %0d expected %0d", result_count, what, got, want);
    end
    mismatch_count++;
  endtask

  function automatic logic pool_exhausted();
    return node_total >= POOL_SIZE || free_ptr >= NIL;
  endfunction

  // Pops a node off the free list and makes it a one-node chain holding v.
  function automatic logic [LINK_W-1:0] take_free_node(logic [VALUE_W-1:0] v);
    logic [LINK_W-1:0] n;
    n = free_ptr;
    free_ptr = node_link[n];
    if (free_ptr > NIL) free_ptr = NIL;
    node_value[n] = v;
    node_link[n] = NIL;
    node_total++;
    return n;
  endfunction

  // First node holding v from the head on; pred is its predecessor or NIL.
  function automatic logic [LINK_W-1:0] find_first(input logic [LINK_W-1:0] start,
                                                   input logic [VALUE_W-1:0] v,
                                                   output logic [LINK_W-1:0] pred);
    logic [LINK_W-1:0] cur, p;
    int unsigned steps;
    cur = start;
    p = NIL;
    pred = NIL;
    for (steps = 0; steps < POOL_SIZE && cur < NIL; steps++) begin
      if (node_value[cur] == v) begin
        pred = p;
        return cur;
      end
      p = cur;
      cur = node_link[cur];
    end
    return NIL;
  endfunction

  // Applies one request to the predictor state and returns the expected result.
  function automatic outcome_t predict_command(command_t c);
    outcome_t          o;
    logic [LINK_W-1:0] head, n, prev, cur;
    logic              used;
    int unsigned       steps;
    o = '0;
    o.status = ST_OK;
    head = list_head[c.list_id];
    used = head < NIL;
    case (c.func)
      FUNC_CREATE: begin
        if (pool_exhausted()) begin
          o.status = ST_FULL;
        end else begin
          n = NIL;
          for (steps = 0; steps < NUM_LISTS; steps++) begin
            if (n == NIL && list_head[steps] >= NIL) n = LINK_W'(steps);
          end
          if (n == NIL) begin
            o.status = ST_NOSLOT;
          end else begin
            cur = take_free_node(c.value);
            list_head[n] = cur;
            o.node_index = cur[NODE_W-1:0];
            o.new_list_id = n[LID_W-1:0];
          end
        end
      end
      FUNC_APPEND: begin
        if (!used) begin
          o.status = ST_UNUSED;
        end else if (pool_exhausted()) begin
          o.status = ST_FULL;
        end else begin
          cur = head;
          for (steps = 1; steps < POOL_SIZE && node_link[cur] < NIL; steps++) begin
            cur = node_link[cur];
          end
          n = take_free_node(c.value);
          node_link[cur] = n;
          o.node_index = n[NODE_W-1:0];
        end
      end
      FUNC_SEARCH: begin
        if (!used) begin
          o.status = ST_UNUSED;
        end else begin
          n = find_first(head, c.value, prev);
          if (n >= NIL) o.status = ST_NOTFOUND;
          else o.node_index = n[NODE_W-1:0];
        end
      end
      FUNC_REMOVE: begin
        if (!used) begin
          o.status = ST_UNUSED;
        end else begin
          n = find_first(head, c.value, prev);
          if (n >= NIL) begin
            o.status = ST_NOTFOUND;
          end else begin
            // Unlink, then push the node back onto the free list.
            if (prev >= NIL) list_head[c.list_id] = node_link[n];
            else node_link[prev] = node_link[n];
            node_link[n] = free_ptr;
            free_ptr = n;
            if (node_total > 0) node_total--;
            o.node_index = n[NODE_W-1:0];
          end
        end
      end
      FUNC_INSERT: begin
        if (!used) begin
          o.status = ST_UNUSED;
        end else if (pool_exhausted()) begin
          o.status = ST_FULL;
        end else begin
          n = find_first(head, c.after_value, prev);
          if (n >= NIL) begin
            o.status = ST_NOTFOUND;
          end else begin
            cur = node_link[n];
            prev = take_free_node(c.value);
            node_link[prev] = cur;
            node_link[n] = prev;
            o.node_index = prev[NODE_W-1:0];
          end
        end
      end
      default: begin
      end
    endcase
    if (o.status != ST_OK) begin
      o.node_index = '0;
      o.new_list_id = '0;
    end
    o.nodes_in_use = node_total[CNT_W-1:0];
    return o;
  endfunction

  // Mostly small values so that searches and removes hit, sometimes any byte.
  function automatic logic [VALUE_W-1:0] draw_byte();
    if ($urandom_range(0, 99) < 85) return VALUE_W'($urandom_range(0, 11));
    return VALUE_W'($urandom_range(0, 255));
  endfunction

  // A growing mix fills the pool and the slots; a shrinking mix empties lists again.
  function automatic command_t draw_command(bit grow);
    command_t    c;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll >= 95) c.func = FUNC_W'($urandom_range(FUNC_RSVD5, FUNC_RSVD7));
    else if (roll < (grow ? 15 : 6)) c.func = FUNC_CREATE;
    else if (roll < (grow ? 45 : 18)) c.func = FUNC_APPEND;
    else if (roll < (grow ? 60 : 35)) c.func = FUNC_SEARCH;
    else if (roll < (grow ? 72 : 81)) c.func = FUNC_REMOVE;
    else c.func = FUNC_INSERT;
    c.value = draw_byte();
    c.after_value = draw_byte();
    c.list_id = LID_W'($urandom_range(0, NUM_LISTS - 1));
    return c;
  endfunction

  task automatic push_command(logic [FUNC_W-1:0] func, logic [VALUE_W-1:0] value,
                              logic [LID_W-1:0] list_id, logic [VALUE_W-1:0] after_value);
    command_t c;
    c.func = func;
    c.value = value;
    c.list_id = list_id;
    c.after_value = after_value;
    command_queue.push_back(c);
  endtask

  // Queues random requests under one idling mix and waits until every result is back.
  task automatic run_phase(int unsigned tx_pct, int unsigned rx_pct, int unsigned count,
                           bit with_stall);
    int unsigned i;
    @(negedge clk_i);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    if (with_stall) begin
      hold_go = 1'b1;
      @(negedge clk_i);
      hold_go = 1'b0;
    end
    for (i = 0; i < count; i++) begin
      command_queue.push_back(draw_command((i / 40) % 2 == 0));
    end
    while (command_queue.size() != 0 || s_axis_tvalid || expected_results.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  // Request driver: predicts each request as it is taken, then offers the next one.
  always @(posedge clk_i) begin : drive_requests
    command_t next_cmd;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_results.push_back(
          predict_command(command_t'(s_axis_tdata[$bits(command_t)-1:0])));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (command_queue.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
          next_cmd = command_queue.pop_front();
          s_axis_tdata <= IN_TDATA_W'(next_cmd);
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Long hold-off of the result channel, counted here.
  always @(posedge clk_i) begin
    if (hold_go) begin
      hold_left <= STALL_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !hold_go && hold_left == 0 && $urandom_range(0, 99) >= rx_idle_pct;
    end
  end

  // Result monitor: each result is checked against the oldest prediction.
  always @(posedge clk_i) begin : check_results
    outcome_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = outcome_t'(m_axis_tdata[$bits(outcome_t)-1:0]);
      if (expected_results.size() == 0) begin
        flag_mismatch("arrived with none pending", m_axis_tdata, '0);
      end else begin
        want = expected_results.pop_front();
        if (got.status !== want.status) flag_mismatch("status", got.status, want.status);
        if (got.node_index !== want.node_index) begin
          flag_mismatch("node_index", got.node_index, want.node_index);
        end
        if (got.new_list_id !== want.new_list_id) begin
          flag_mismatch("new_list_id", got.new_list_id, want.new_list_id);
        end
        if (got.nodes_in_use !== want.nodes_in_use) begin
          flag_mismatch("nodes_in_use", got.nodes_in_use, want.nodes_in_use);
        end
      end
      result_count++;
    end
  end

  initial begin : stimulus
    int unsigned i;
    // Empty pool: every node on the free list in order, no list in use.
    for (i = 0; i < POOL_SIZE; i++) begin
      node_value[i] = '0;
      node_link[i] = LINK_W'(i + 1);
    end
    for (i = 0; i < NUM_LISTS; i++) list_head[i] = NIL;
    free_ptr = '0;
    node_total = 0;

    // Directed opening: unused list, no-op codes, all slots taken, pool filled up.
    push_command(FUNC_SEARCH, 8'h00, 3'd0, 8'h00);
    push_command(FUNC_RSVD5, 8'hFF, 3'd7, 8'hFF);
    push_command(FUNC_RSVD7, 8'h00, 3'd0, 8'h00);
    push_command(FUNC_CREATE, 8'h00, 3'd7, 8'h00);
    push_command(FUNC_CREATE, 8'hFF, 3'd0, 8'hFF);
    push_command(FUNC_CREATE, 8'h01, 3'd5, 8'h00);
    push_command(FUNC_CREATE, 8'h02, 3'd2, 8'h00);
    push_command(FUNC_CREATE, 8'h80, 3'd0, 8'h00);
    push_command(FUNC_CREATE, 8'h7F, 3'd0, 8'h00);
    push_command(FUNC_CREATE, 8'h03, 3'd0, 8'h00);
    push_command(FUNC_CREATE, 8'h04, 3'd0, 8'h00);
    push_command(FUNC_CREATE, 8'h05, 3'd0, 8'h00);
    push_command(FUNC_SEARCH, 8'h00, 3'd0, 8'h00);
    // The lone node of list 0 is head and tail at once.
    push_command(FUNC_INSERT, 8'hA5, 3'd0, 8'h00);
    for (i = 0; i < 7; i++) begin
      push_command(FUNC_APPEND, VALUE_W'(8'h10 + i), 3'd0, 8'h00);
    end
    // The pool is now full.
    push_command(FUNC_CREATE, 8'h06, 3'd0, 8'h00);
    push_command(FUNC_APPEND, 8'h07, 3'd3, 8'h00);
    push_command(FUNC_INSERT, 8'h08, 3'd2, 8'h01);
    // Removing the only node of list 1 frees its slot.
    push_command(FUNC_REMOVE, 8'hFF, 3'd1, 8'h00);
    push_command(FUNC_INSERT, 8'h5A, 3'd0, 8'hEE);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    run_phase(19, 52, 230, 1'b0);
    run_phase(52, 19, 230, 1'b0);
    run_phase(0, 0, 240, 1'b1);

    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
